FILE: hw/rtl/stt_pkg.sv
`default_nettype none
package stt_pkg;

  localparam int unsigned MAX_SOURCE_LEN_DEF  = 65536;
  localparam int unsigned KEYWORD_BUF_LEN_DEF = 9;
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam int unsigned NUM_KEYWORDS        = 17;
  localparam int unsigned KW_MAX_LEN          = 9;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_SEMI    = 6'd4;
  localparam logic [5:0] K_COMMA   = 6'd5;
  localparam logic [5:0] K_DOT     = 6'd6;
  localparam logic [5:0] K_MINUS   = 6'd7;
  localparam logic [5:0] K_PLUS    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_COLON   = 6'd11;
  localparam logic [5:0] K_BANG    = 6'd12;
  localparam logic [5:0] K_EQUAL   = 6'd14;
  localparam logic [5:0] K_LESS    = 6'd16;
  localparam logic [5:0] K_GREATER = 6'd18;
  localparam logic [5:0] K_NUMBER  = 6'd20;
  localparam logic [5:0] K_STRING  = 6'd21;
  localparam logic [5:0] K_IDENT   = 6'd22;
  localparam logic [5:0] K_EOF     = 6'd40;
  localparam logic [5:0] K_ERROR   = 6'd41;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_UNTERM = 2'd1;
  localparam logic [1:0] ERR_UNEXP  = 2'd2;

  localparam logic [71:0] KW_TEXT [NUM_KEYWORDS] = '{
    72'("and"), 72'("if"), 72'("return"), 72'("while"), 72'("let"), 72'("false"),
    72'("for"), 72'("fn"), 72'("nil"), 72'("display"), 72'("done"), 72'("do"),
    72'("or"), 72'("otherwise"), 72'("else"), 72'("then"), 72'("true")
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd2, 4'd6, 4'd5, 4'd3, 4'd5, 4'd3, 4'd2, 4'd3, 4'd7, 4'd4, 4'd2,
    4'd2, 4'd9, 4'd4, 4'd4, 4'd4
  };
  localparam logic [5:0] KW_KIND [NUM_KEYWORDS] = '{
    6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
  } token_t;

  // up to three tokens caused by one byte
  typedef struct packed {
    logic [1:0]      cnt;
    token_t [2:0]    tok;
  } bundle_t;

endpackage
`default_nettype wire

FILE: hw/rtl/stt_front.sv
`default_nettype none
module stt_front #(
  parameter int unsigned MAX_SOURCE_LEN  = stt_pkg::MAX_SOURCE_LEN_DEF,
  parameter int unsigned KEYWORD_BUF_LEN = stt_pkg::KEYWORD_BUF_LEN_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [7:0]       char_byte_i,
  output logic                  ready_o,
  output logic                  push_o,
  output stt_pkg::bundle_t      bundle_o,
  input  wire logic             full_i
);

  localparam logic [15:0] POS_MAX = (MAX_SOURCE_LEN - 1 > 65535) ? 16'hFFFF
                                  : 16'(MAX_SOURCE_LEN - 1);
  localparam int unsigned IDXW = $clog2(KEYWORD_BUF_LEN);

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_INT     = 8'b0000_0100,
    M_DOT     = 8'b0000_1000,
    M_FRAC    = 8'b0001_0000,
    M_IDENT   = 8'b0010_0000,
    M_STRING  = 8'b0100_0000,
    M_OP      = 8'b1000_0000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] pos_q, pos_d, start_q, start_d, line_q, line_d, lex_q, lex_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  prefix_q [KEYWORD_BUF_LEN];
  logic        pre_we;
  logic [IDXW-1:0] pre_idx;

  logic [7:0]  c;
  logic        acc;
  logic        is_dig, is_alp, line_inc;
  logic [2:0]  cand_v;
  stt_pkg::token_t cand [3];
  stt_pkg::token_t fin0, fin1, beg_t;
  logic        fin0_v, fin1_v, beg_v;
  mode_e       beg_mode;
  logic        beg_start, beg_line, beg_pend, beg_pre;
  logic [5:0]  wkind, skind;
  logic        skind_v, kw_m;
  logic [5:0]  pbase;
  logic [1:0]  k;

  assign c       = char_byte_i;
  assign ready_o = !full_i;
  assign acc     = valid_i && ready_o;
  assign is_dig  = (c >= "0") && (c <= "9");
  assign is_alp  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");

  function automatic stt_pkg::token_t mk(logic [5:0] kd, logic [1:0] er,
                                         logic [15:0] st, logic [15:0] ln,
                                         logic [15:0] li);
    stt_pkg::token_t t;
    t.kind = kd; t.err = er; t.start = st; t.len = ln; t.line = li;
    return t;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] v, logic [1:0] by);
    logic [16:0] s;
    s = {1'b0, v} + {15'd0, by};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // keyword lookup over the stored prefix
  always_comb begin
    wkind = stt_pkg::K_IDENT;
    for (int i = stt_pkg::NUM_KEYWORDS - 1; i >= 0; i--) begin
      kw_m = (lex_q == {12'd0, stt_pkg::KW_LEN[i]});
      for (int j = 0; j < stt_pkg::KW_MAX_LEN; j++) begin
        if (j < int'(stt_pkg::KW_LEN[i])) begin
          kw_m = kw_m && (prefix_q[j] ==
                 stt_pkg::KW_TEXT[i][8*(int'(stt_pkg::KW_LEN[i]) - 1 - j) +: 8]);
        end
      end
      if (kw_m) wkind = stt_pkg::KW_KIND[i];
    end
  end

  always_comb begin
    skind_v = 1'b1;
    case (c)
      "(":     skind = stt_pkg::K_LPAREN;
      ")":     skind = stt_pkg::K_RPAREN;
      "{":     skind = stt_pkg::K_LBRACE;
      "}":     skind = stt_pkg::K_RBRACE;
      ";":     skind = stt_pkg::K_SEMI;
      ",":     skind = stt_pkg::K_COMMA;
      ".":     skind = stt_pkg::K_DOT;
      "-":     skind = stt_pkg::K_MINUS;
      "+":     skind = stt_pkg::K_PLUS;
      "/":     skind = stt_pkg::K_SLASH;
      "*":     skind = stt_pkg::K_STAR;
      ":":     skind = stt_pkg::K_COLON;
      default: begin
        skind   = stt_pkg::K_ERROR;
        skind_v = 1'b0;
      end
    endcase
    case (pend_q)
      "!":     pbase = stt_pkg::K_BANG;
      "=":     pbase = stt_pkg::K_EQUAL;
      "<":     pbase = stt_pkg::K_LESS;
      default: pbase = stt_pkg::K_GREATER;
    endcase
  end

  // tokens that close the lexeme in progress
  always_comb begin
    fin0_v = 1'b0;
    fin1_v = 1'b0;
    fin0   = mk(stt_pkg::K_NUMBER, stt_pkg::ERR_NONE, start_q, lex_q, line_q);
    fin1   = mk(stt_pkg::K_DOT, stt_pkg::ERR_NONE, (pos_q != 16'd0) ? pos_q - 16'd1 : 16'd0,
                16'd1, line_q);
    case (mode_q)
      M_INT, M_FRAC: fin0_v = 1'b1;
      M_DOT: begin
        fin0_v = 1'b1;
        fin1_v = 1'b1;
      end
      M_IDENT: begin
        fin0_v    = 1'b1;
        fin0.kind = wkind;
      end
      M_OP: begin
        fin0_v    = 1'b1;
        fin0.kind = pbase;
        fin0.len  = 16'd1;
      end
      default: ;
    endcase
  end

  // start of a new lexeme from the current byte
  always_comb begin
    beg_mode  = M_IDLE;
    beg_line  = 1'b0;
    beg_start = 1'b0;
    beg_pend  = 1'b0;
    beg_pre   = 1'b0;
    beg_v     = 1'b0;
    beg_t     = mk(skind, stt_pkg::ERR_NONE, pos_q, 16'd1, line_q);
    if (c == " " || c == 8'h09 || c == 8'h0D) begin
    end else if (c == 8'h0A) begin
      beg_line = 1'b1;
    end else if (c == "#") begin
      beg_mode = M_COMMENT;
    end else begin
      beg_start = 1'b1;
      if (is_dig) begin
        beg_mode = M_INT;
      end else if (is_alp) begin
        beg_mode = M_IDENT;
        beg_pre  = 1'b1;
      end else if (c == "\"") begin
        beg_mode = M_STRING;
      end else if (c == "!" || c == "=" || c == "<" || c == ">") begin
        beg_mode = M_OP;
        beg_pend = 1'b1;
      end else begin
        beg_v = 1'b1;
        if (!skind_v) beg_t.err = stt_pkg::ERR_UNEXP;
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    lex_d    = lex_q;
    pend_d   = pend_q;
    line_inc = 1'b0;
    pre_we   = 1'b0;
    pre_idx  = lex_q[IDXW-1:0];
    cand_v   = 3'b000;
    cand[0]  = fin0;
    cand[1]  = fin1;
    cand[2]  = beg_t;
    pos_d    = (pos_q < POS_MAX) ? pos_q + 16'd1 : pos_q;

    if (c == 8'd0) begin
      if (mode_q == M_STRING) begin
        cand_v[0] = 1'b1;
        cand[0]   = mk(stt_pkg::K_ERROR, stt_pkg::ERR_UNTERM, start_q, lex_q, line_q);
      end else begin
        cand_v[1:0] = {fin1_v, fin0_v};
      end
      cand_v[2] = 1'b1;
      cand[2]   = mk(stt_pkg::K_EOF, stt_pkg::ERR_NONE, pos_q, 16'd0, line_q);
      mode_d    = M_IDLE;
      pos_d     = 16'd0;
      start_d   = 16'd0;
      lex_d     = 16'd0;
      pend_d    = 8'd0;
    end else begin
      // default path: close the lexeme and rescan this byte
      logic restart;
      restart = 1'b0;
      case (mode_q)
        M_COMMENT: begin
          if (c == 8'h0A) begin
            line_inc = 1'b1;
            mode_d   = M_IDLE;
          end
        end
        M_INT: begin
          if (is_dig) lex_d = sat_add(lex_q, 2'd1);
          else if (c == ".") mode_d = M_DOT;
          else restart = 1'b1;
        end
        M_DOT: begin
          if (is_dig) begin
            lex_d  = sat_add(lex_q, 2'd2);
            mode_d = M_FRAC;
          end else restart = 1'b1;
        end
        M_FRAC: begin
          if (is_dig) lex_d = sat_add(lex_q, 2'd1);
          else restart = 1'b1;
        end
        M_IDENT: begin
          if (is_alp || is_dig) begin
            pre_we = (lex_q < 16'(KEYWORD_BUF_LEN));
            lex_d  = sat_add(lex_q, 2'd1);
          end else restart = 1'b1;
        end
        M_STRING: begin
          lex_d = sat_add(lex_q, 2'd1);
          if (c == "\"") begin
            cand_v[0] = 1'b1;
            cand[0]   = mk(stt_pkg::K_STRING, stt_pkg::ERR_NONE, start_q, lex_d, line_q);
            mode_d    = M_IDLE;
          end else if (c == 8'h0A) begin
            line_inc = 1'b1;
          end
        end
        M_OP: begin
          if (c == "=") begin
            cand_v[0] = 1'b1;
            cand[0]   = mk(pbase + 6'd1, stt_pkg::ERR_NONE, start_q, 16'd2, line_q);
            mode_d    = M_IDLE;
          end else restart = 1'b1;
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        cand_v   = {beg_v, fin1_v, fin0_v};
        mode_d   = beg_mode;
        line_inc = beg_line;
        if (beg_start) begin
          start_d = pos_q;
          lex_d   = 16'd1;
        end
        if (beg_pend) pend_d = c;
        if (beg_pre) begin
          pre_we  = 1'b1;
          pre_idx = '0;
        end
      end
    end

    if (c == 8'd0) line_d = 16'd1;
    else if (line_inc && line_q != 16'hFFFF) line_d = line_q + 16'd1;
    else line_d = line_q;
  end

  // pack valid candidates in order
  always_comb begin
    bundle_o = '0;
    k        = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        bundle_o.tok[k] = cand[i];
        k = k + 2'd1;
      end
    end
    bundle_o.cnt = k;
    push_o       = acc && (cand_v != 3'b000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= 16'd0;
      start_q <= 16'd0;
      line_q  <= 16'd1;
      lex_q   <= 16'd0;
      pend_q  <= 8'd0;
    end else if (acc) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      line_q  <= line_d;
      lex_q   <= lex_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && pre_we && c != 8'd0) prefix_q[pre_idx] <= c;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/stt_queue.sv
`default_nettype none
module stt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  stt_pkg::bundle_t      data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output stt_pkg::bundle_t      head_o
);

  localparam int unsigned PW = (stt_pkg::QUEUE_DEPTH > 1) ? $clog2(stt_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(stt_pkg::QUEUE_DEPTH + 1);

  stt_pkg::bundle_t mem_q [stt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(stt_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  function automatic logic [PW-1:0] nxt(logic [PW-1:0] p);
    return (p == PW'(stt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= nxt(wp_q);
      if (pop_i)  rp_q <= nxt(rp_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/stt_back.sv
`default_nettype none
module stt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  stt_pkg::bundle_t      head_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output stt_pkg::token_t       tok_o,
  output logic                  last_o
);

  logic [1:0] idx_q;

  assign valid_o = !empty_i;
  assign tok_o   = head_i.tok[idx_q];
  assign last_o  = (idx_q == head_i.cnt - 2'd1);
  assign pop_o   = valid_o && ready_i && last_o;

  // step through the tokens of the head item, drop it after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (valid_o && ready_i) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/source_text_tokenizer.sv
`default_nettype none
// Streaming lexical scanner: one source byte per cycle in, one token per cycle out
// as out_ready_i allows. A byte is taken every cycle while the two-entry token queue
// has room; a byte that closes one lexeme and opens another can yield up to three
// tokens, which leave one per cycle, so the sustained rate is one byte per cycle as
// long as bytes average at most one token each. Byte 0 ends a source, emits EOF and
// restarts all counters. Offsets saturate at MAX_SOURCE_LEN - 1, lengths and line
// numbers at 65535; last_of_run_o marks the last token caused by one input byte.
module source_text_tokenizer #(
  parameter int unsigned MAX_SOURCE_LEN  = stt_pkg::MAX_SOURCE_LEN_DEF,
  parameter int unsigned KEYWORD_BUF_LEN = stt_pkg::KEYWORD_BUF_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       token_kind_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      start_offset_o,
  output logic [15:0]      token_length_o,
  output logic [15:0]      line_number_o,
  output logic             last_of_run_o
);

  logic push, full, pop, empty;
  stt_pkg::bundle_t in_b, head_b;
  stt_pkg::token_t  tok;

  stt_front #(
    .MAX_SOURCE_LEN (MAX_SOURCE_LEN),
    .KEYWORD_BUF_LEN(KEYWORD_BUF_LEN)
  ) u_front (
    .clk_i, .rst_ni,
    .valid_i    (in_valid_i),
    .char_byte_i,
    .ready_o    (in_ready_o),
    .push_o     (push),
    .bundle_o   (in_b),
    .full_i     (full)
  );

  stt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (in_b),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_b)
  );

  stt_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .head_i  (head_b),
    .pop_o   (pop),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .tok_o   (tok),
    .last_o  (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign error_code_o   = tok.err;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign line_number_o  = tok.line;

endmodule
`default_nettype wire
